/* design/assert_macros.svh */
// assertion macros for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, masked during reset
`define CHK_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

/* design/mrfa_pkg.sv */
// shared types and constants of the resource allocator
package mrfa_pkg;
  localparam int NumResourcesDef = 4;
  localparam int QueueDepthDef = 16;
  localparam int NumCfg = 4;
  localparam int UnitW = 16;
  localparam int JobW = 16;
  localparam int SrcW = 64;

  localparam logic [2:0] StGranted = 3'd0;
  localparam logic [2:0] StQueued = 3'd1;
  localparam logic [2:0] StRejected = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StQGrant = 3'd4;
  localparam logic [2:0] StRelDone = 3'd5;

  localparam logic ReqReserve = 1'b0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture request
    logic reserve;   // apply reserve decision
    logic rel_add;   // add back granted units
    logic scan_rd;   // issue read of scan slot
    logic scan_wr;   // compacting write of scan entry
    logic scan_done; // commit new count
    logic head_rd;   // read queue head
    logic grant;     // consume queue head
    logic emit_req;  // load output with request echo
    logic emit_head; // load output with head entry
    logic [2:0] status;
    logic last;
  } mrfa_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic bad_index;
    logic is_reserve;
    logic granted_rel;
    logic scan_more;
    logic head_ok;
    logic out_busy;
    logic [2:0] res_status;
  } mrfa_sts_t;
endpackage

/* design/mrfa_datapath.sv */
// datapath: counts, queue memories, compaction and output register
module mrfa_datapath #(
  parameter int RES_COUNT = mrfa_pkg::NumResourcesDef,
  parameter int QUEUE_DEPTH = mrfa_pkg::QueueDepthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0] resource_index,
  input  logic req_type,
  input  logic [15:0] job_id,
  input  logic [63:0] src_id,
  input  logic [15:0] amount,
  input  logic was_granted,
  input  mrfa_pkg::mrfa_cmd_t cmd,
  output mrfa_pkg::mrfa_sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] status,
  output logic [15:0] out_job,
  output logic [63:0] out_src,
  output logic last
);
  localparam int RW = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = RES_COUNT * QUEUE_DEPTH;
  localparam int AW = $clog2(MD);
  localparam int EW = mrfa_pkg::JobW + mrfa_pkg::SrcW + mrfa_pkg::UnitW;

  logic [15:0] capacity [RES_COUNT];
  logic [15:0] avail [RES_COUNT];
  logic [QW-1:0] head [RES_COUNT];
  logic [CW-1:0] count [RES_COUNT];
  logic [EW-1:0] mem [MD];
  logic [EW-1:0] rd_data;

  logic q_type, q_gr, q_bad;
  logic [RW-1:0] q_r;
  logic [15:0] q_job, q_amt;
  logic [63:0] q_src;
  logic [CW-1:0] rd_idx, kept;
  logic rd_pend;
  logic [2:0] res_st;

  logic [15:0] cap_r, av_r;
  logic [QW-1:0] hd_r;
  logic [CW-1:0] cn_r;
  logic [QW-1:0] rd_slot, wr_slot, tail_slot;
  logic [16:0] av_sum;
  logic match;

  assign cap_r = capacity[q_r];
  assign av_r = avail[q_r];
  assign hd_r = head[q_r];
  assign cn_r = count[q_r];

  // circular slot of head plus offset
  function automatic logic [QW-1:0] wrap(input logic [QW-1:0] h,
                                         input logic [CW-1:0] o);
    logic [QW+1:0] s;
    s = {2'b00, h} + {{(QW+2-CW){1'b0}}, o};
    if (s >= (QW+2)'(QUEUE_DEPTH)) s = s - (QW+2)'(QUEUE_DEPTH);
    return s[QW-1:0];
  endfunction

  assign rd_slot = wrap(hd_r, rd_idx);
  assign wr_slot = wrap(hd_r, kept);
  assign tail_slot = wrap(hd_r, cn_r);
  assign av_sum = {1'b0, av_r} + {1'b0, q_amt};
  assign match = (rd_data[EW-1 -: 16] == q_job) && (rd_data[EW-17 -: 64] == q_src);

  function automatic logic [AW-1:0] addr(input logic [RW-1:0] r,
                                         input logic [QW-1:0] s);
    return AW'(r) * AW'(QUEUE_DEPTH) + AW'(s);
  endfunction

  // reserve decision
  always_comb begin
    if ({1'b0, q_amt} > {1'b0, cap_r}) res_st = mrfa_pkg::StRejected;
    else if (av_r >= q_amt) res_st = mrfa_pkg::StGranted;
    else if (cn_r >= CW'(QUEUE_DEPTH)) res_st = mrfa_pkg::StFull;
    else res_st = mrfa_pkg::StQueued;
  end

  assign sts.bad_index = q_bad;
  assign sts.is_reserve = (q_type == mrfa_pkg::ReqReserve);
  assign sts.granted_rel = q_gr;
  assign sts.scan_more = (rd_idx < cn_r);
  assign sts.head_ok = (cn_r != '0) && (av_r >= rd_data[15:0]);
  assign sts.out_busy = out_valid;
  assign sts.res_status = res_st;

  // queue memory, one port each way, read data registered
  always_ff @(posedge clk) begin
    if (cmd.reserve && res_st == mrfa_pkg::StQueued)
      mem[addr(q_r, tail_slot)] <= {q_job, q_src, q_amt};
    else if (cmd.scan_wr && !match && rd_pend)
      mem[addr(q_r, wr_slot)] <= rd_data;
    if (cmd.scan_rd) rd_data <= mem[addr(q_r, rd_slot)];
    else if (cmd.head_rd) rd_data <= mem[addr(q_r, hd_r)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RES_COUNT; i++) begin
        capacity[i] <= '0;
        avail[i] <= '0;
        head[i] <= '0;
        count[i] <= '0;
      end
      out_valid <= 1'b0;
      rd_idx <= '0;
      kept <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg_valid && 32'(cfg_index) < RES_COUNT) begin
        capacity[RW'(cfg_index)] <= cfg_data;
        avail[RW'(cfg_index)] <= cfg_data;
      end
      if (cmd.load) begin
        rd_idx <= '0;
        kept <= '0;
        rd_pend <= 1'b0;
      end
      if (cmd.reserve) begin
        if (res_st == mrfa_pkg::StGranted) avail[q_r] <= av_r - q_amt;
        if (res_st == mrfa_pkg::StQueued) count[q_r] <= cn_r + CW'(1);
      end
      if (cmd.rel_add)
        avail[q_r] <= (av_sum > {1'b0, cap_r}) ? cap_r : av_sum[15:0];
      if (cmd.scan_rd) rd_idx <= rd_idx + CW'(1);
      rd_pend <= cmd.scan_rd;
      if (cmd.scan_wr && rd_pend && !match) kept <= kept + CW'(1);
      if (cmd.scan_done) count[q_r] <= kept;
      if (cmd.grant) begin
        avail[q_r] <= av_r - rd_data[15:0];
        head[q_r] <= wrap(hd_r, CW'(1));
        count[q_r] <= cn_r - CW'(1);
      end
      if (cmd.emit_req || cmd.emit_head) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // request capture and output register (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_type <= req_type;
      q_gr <= was_granted;
      q_bad <= 32'(resource_index) >= RES_COUNT;
      q_r <= RW'(resource_index);
      q_job <= job_id;
      q_src <= src_id;
      q_amt <= amount;
    end
    if (cmd.emit_req) begin
      status <= cmd.status;
      out_job <= q_job;
      out_src <= q_src;
      last <= cmd.last;
    end else if (cmd.emit_head) begin
      status <= mrfa_pkg::StQGrant;
      out_job <= rd_data[EW-1 -: 16];
      out_src <= rd_data[EW-17 -: 64];
      last <= 1'b0;
    end
  end
endmodule

/* design/mrfa_ctrl.sv */
// controller state machine sequencing each request
module mrfa_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mrfa_pkg::mrfa_sts_t sts,
  output mrfa_pkg::mrfa_cmd_t cmd
);
  typedef enum logic [3:0] {
    IDLE, DECIDE, SCAN, SCAN_END, HEAD_RD, HEAD_CHK, FINISH, DRAIN
  } state_t;
  state_t state;

  assign in_ready = (state == IDLE) && !sts.out_busy;

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: cmd.load = in_valid && in_ready;
      DECIDE: begin
        if (!sts.out_busy) begin
          if (sts.bad_index) begin
            cmd.emit_req = 1'b1; cmd.status = mrfa_pkg::StRejected; cmd.last = 1'b1;
          end else if (sts.is_reserve) begin
            cmd.reserve = 1'b1; cmd.emit_req = 1'b1;
            cmd.status = sts.res_status; cmd.last = 1'b1;
          end else if (sts.granted_rel) begin
            cmd.rel_add = 1'b1;
          end else begin
            cmd.scan_rd = sts.scan_more;
          end
        end
      end
      SCAN: begin
        cmd.scan_wr = 1'b1;
        cmd.scan_rd = sts.scan_more;
      end
      SCAN_END: cmd.scan_done = 1'b1;
      HEAD_RD: cmd.head_rd = 1'b1;
      HEAD_CHK: begin
        if (!sts.out_busy) begin
          if (sts.head_ok) begin
            cmd.grant = 1'b1; cmd.emit_head = 1'b1;
          end
        end
      end
      FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit_req = 1'b1; cmd.status = mrfa_pkg::StRelDone; cmd.last = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: if (cmd.load) state <= DECIDE;
        DECIDE: begin
          if (!sts.out_busy) begin
            if (sts.bad_index || sts.is_reserve) state <= DRAIN;
            else if (sts.granted_rel) state <= HEAD_RD;
            else if (sts.scan_more) state <= SCAN;
            else state <= HEAD_RD;
          end
        end
        SCAN: if (!sts.scan_more) state <= SCAN_END;
        SCAN_END: state <= HEAD_RD;
        HEAD_RD: state <= HEAD_CHK;
        HEAD_CHK: begin
          if (!sts.out_busy) state <= sts.head_ok ? HEAD_RD : FINISH;
        end
        FINISH: if (!sts.out_busy) state <= DRAIN;
        DRAIN: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

/* design/multi_resource_fifo_allocator.sv */
// top level: per-resource counting semaphore with fifo wait queues
// reserve or bad index: the result is loaded from DECIDE, then DRAIN returns to IDLE
// release: DECIDE, then a cancel scan (SCAN, SCAN_END), then HEAD_RD and HEAD_CHK for each
// queued grant, then FINISH and DRAIN back to IDLE; grants wait for a taken result
// one request in flight at a time; the queue memory's single read port sets the pace
// synchronous reset clears counts, capacities, heads and fills; queue entries undefined
module multi_resource_fifo_allocator #(
  parameter int RES_COUNT = mrfa_pkg::NumResourcesDef,
  parameter int QUEUE_DEPTH = mrfa_pkg::QueueDepthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [2:0] resource_index,
  input  logic [15:0] job_id,
  input  logic [63:0] src_id,
  input  logic [15:0] amount,
  input  logic was_granted,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] status,
  output logic [15:0] out_job,
  output logic [63:0] out_src,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  `include "assert_macros.svh"

  mrfa_pkg::mrfa_cmd_t cmd;
  mrfa_pkg::mrfa_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  mrfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  mrfa_datapath #(.RES_COUNT(RES_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .resource_index(resource_index), .req_type(req_type), .job_id(job_id),
    .src_id(src_id), .amount(amount), .was_granted(was_granted),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_job(out_job), .out_src(out_src), .last(last)
  );

  // no new request while a result still waits
  `CHK_IMP(a_no_accept_busy, in_valid && in_ready, !out_valid)
  // a queued grant result is never the last one
  `CHK_IMP(a_grant_not_last, out_valid && status == mrfa_pkg::StQGrant, !last)
  // emitting a result always makes it visible next cycle
  `CHK_NXT(a_emit_valid, cmd.emit_req || cmd.emit_head, out_valid)
endmodule

/* sim/multi_resource_fifo_allocator_tb.sv */
// testbench for the multi-resource fifo allocator: random and directed requests against a predictor
`timescale 1ns / 100ps

module multi_resource_fifo_allocator_tb;
  localparam int NRES = 4;
  localparam int QDEPTH = 16;

  typedef struct {
    bit        kind;       // reserve or release
    bit [2:0]  ridx;
    bit [15:0] job;
    bit [63:0] src;
    bit [15:0] amt;
    bit        granted;
  } alloc_req_t;

  typedef struct {
    bit [2:0]  st;
    bit [15:0] job;
    bit [63:0] src;
    bit        fin;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [2:0] resource_index = '0;
  logic [15:0] job_id = '0;
  logic [63:0] src_id = '0;
  logic [15:0] amount = '0;
  logic was_granted = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [15:0] out_job;
  logic [63:0] out_src;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  bit [15:0] cap_units [NRES];
  bit [15:0] free_units [NRES];
  bit [15:0] wq_job [NRES][QDEPTH];
  bit [63:0] wq_src [NRES][QDEPTH];
  bit [15:0] wq_amt [NRES][QDEPTH];
  int unsigned wq_head [NRES];
  int unsigned wq_fill [NRES];

  alloc_req_t pending_reqs[$];
  alloc_res_t expected_results[$];
  alloc_req_t cur_req;

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit sender_pause = 1'b0;
  int phase_no = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  bit [63:0] src_pool [3] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0};

  multi_resource_fifo_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .resource_index(resource_index), .job_id(job_id),
    .src_id(src_id), .amount(amount), .was_granted(was_granted),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_job(out_job), .out_src(out_src), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void push_result(bit [2:0] st, bit [15:0] job, bit [63:0] src, bit fin);
    alloc_res_t r;
    r.st = st;
    r.job = job;
    r.src = src;
    r.fin = fin;
    expected_results.push_back(r);
  endfunction

  // work out the results of one accepted request and update the allocator image
  function automatic void predict_allocation(alloc_req_t q);
    int unsigned r, s, kept, sum;
    bit [15:0] kj [QDEPTH];
    bit [63:0] ks [QDEPTH];
    bit [15:0] ka [QDEPTH];
    r = q.ridx;
    if (r >= NRES) begin
      push_result(mrfa_pkg::StRejected, q.job, q.src, 1'b1);
      return;
    end
    if (q.kind == mrfa_pkg::ReqReserve) begin
      if (q.amt > cap_units[r]) begin
        push_result(mrfa_pkg::StRejected, q.job, q.src, 1'b1);
      end else if (free_units[r] >= q.amt) begin
        free_units[r] -= q.amt;
        push_result(mrfa_pkg::StGranted, q.job, q.src, 1'b1);
      end else if (wq_fill[r] >= QDEPTH) begin
        push_result(mrfa_pkg::StFull, q.job, q.src, 1'b1);
      end else begin
        s = (wq_head[r] + wq_fill[r]) % QDEPTH;
        wq_job[r][s] = q.job;
        wq_src[r][s] = q.src;
        wq_amt[r][s] = q.amt;
        wq_fill[r]++;
        push_result(mrfa_pkg::StQueued, q.job, q.src, 1'b1);
      end
      return;
    end
    if (q.granted) begin
      sum = free_units[r] + q.amt;
      free_units[r] = (sum > cap_units[r]) ? cap_units[r] : sum[15:0];
    end else begin
      // cancel: drop every matching waiter, keep order of the rest
      kept = 0;
      for (int i = 0; i < wq_fill[r]; i++) begin
        s = (wq_head[r] + i) % QDEPTH;
        if (!(wq_job[r][s] == q.job && wq_src[r][s] == q.src)) begin
          kj[kept] = wq_job[r][s];
          ks[kept] = wq_src[r][s];
          ka[kept] = wq_amt[r][s];
          kept++;
        end
      end
      for (int i = 0; i < kept; i++) begin
        s = (wq_head[r] + i) % QDEPTH;
        wq_job[r][s] = kj[i];
        wq_src[r][s] = ks[i];
        wq_amt[r][s] = ka[i];
      end
      wq_fill[r] = kept;
    end
    // grant queued heads while units suffice
    while (wq_fill[r] > 0) begin
      s = wq_head[r];
      if (free_units[r] < wq_amt[r][s]) break;
      free_units[r] -= wq_amt[r][s];
      push_result(mrfa_pkg::StQGrant, wq_job[r][s], wq_src[r][s], 1'b0);
      wq_head[r] = (s + 1) % QDEPTH;
      wq_fill[r]--;
    end
    push_result(mrfa_pkg::StRelDone, q.job, q.src, 1'b1);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_allocation(cur_req);
      if (!in_valid || in_ready) begin
        if (!sender_pause && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_req = pending_reqs.pop_front();
          req_type <= cur_req.kind;
          resource_index <= cur_req.ridx;
          job_id <= cur_req.job;
          src_id <= cur_req.src;
          amount <= cur_req.amt;
          was_granted <= cur_req.granted;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off in the pressure phase, counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (phase_no == 3 && !hold_done) begin
      hold_left <= 500;
      hold_done <= 1'b1;
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", 64'(status), 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (status !== e.st) report_mismatch("status", 64'(status), 64'(e.st));
          if (out_job !== e.job) report_mismatch("out_job", 64'(out_job), 64'(e.job));
          if (out_src !== e.src) report_mismatch("out_src", out_src, e.src);
          if (last !== e.fin) report_mismatch("last", 64'(last), 64'(e.fin));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_capacity(int idx, bit [15:0] val);
    @(posedge clk);
    cfg_index <= idx[1:0];
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_units[idx] = val;
    free_units[idx] = val;
  endtask

  task automatic set_capacities(bit [15:0] c0, bit [15:0] c1, bit [15:0] c2, bit [15:0] c3);
    write_capacity(0, c0);
    write_capacity(1, c1);
    write_capacity(2, c2);
    write_capacity(3, c3);
  endtask

  task automatic add_req(bit kind, bit [2:0] ridx, bit [15:0] job, bit [63:0] src,
                         bit [15:0] amt, bit granted);
    alloc_req_t q;
    q.kind = kind;
    q.ridx = ridx;
    q.job = job;
    q.src = src;
    q.amt = amt;
    q.granted = granted;
    pending_reqs.push_back(q);
  endtask

  // mostly well-formed traffic on a small id pool so cancels hit, plus noise
  task automatic add_random_req();
    int unsigned r, c, sel;
    bit [15:0] job;
    bit [63:0] src;
    r = $urandom_range(NRES - 1);
    c = cap_units[r];
    job = 16'h0100 + 16'($urandom_range(5));
    src = src_pool[$urandom_range(2)];
    sel = $urandom_range(99);
    if (sel < 45) begin
      add_req(mrfa_pkg::ReqReserve, 3'(r), job, src,
              16'(($urandom_range(9) == 0 && c < 65535) ? c + 1 : $urandom_range(c)), 1'b0);
    end else if (sel < 70) begin
      add_req(~mrfa_pkg::ReqReserve, 3'(r), job, src, 16'($urandom_range(c)), 1'b1);
    end else if (sel < 88) begin
      add_req(~mrfa_pkg::ReqReserve, 3'(r), job, src, 16'($urandom), 1'b0);
    end else if (sel < 94) begin
      add_req(1'($urandom_range(1)), 3'($urandom_range(7, NRES)), 16'($urandom),
              {$urandom, $urandom}, 16'($urandom), 1'($urandom_range(1)));
    end else begin
      add_req(1'($urandom_range(1)), 3'($urandom_range(7)), 16'($urandom),
              {$urandom, $urandom}, 16'($urandom), 1'($urandom_range(1)));
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) add_random_req();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, bad index, queueing, cancel, saturation, full queue
    set_capacities(16'd0, 16'd5, 16'hFFFF, 16'd1);
    add_req(mrfa_pkg::ReqReserve, 3'd0, 16'h0000, 64'h0, 16'd0, 1'b0);
    add_req(mrfa_pkg::ReqReserve, 3'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 1'b0);
    add_req(mrfa_pkg::ReqReserve, 3'd7, 16'h1111, 64'h1, 16'd1, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd4, 16'h2222, 64'h2, 16'd1, 1'b1);
    add_req(mrfa_pkg::ReqReserve, 3'd2, 16'h0003, 64'h3, 16'hFFFF, 1'b0);
    add_req(mrfa_pkg::ReqReserve, 3'd2, 16'h0004, 64'h4, 16'd1, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd2, 16'h0003, 64'h3, 16'hFFFF, 1'b1);
    add_req(mrfa_pkg::ReqReserve, 3'd1, 16'h00A0, 64'hA, 16'd5, 1'b0);
    add_req(mrfa_pkg::ReqReserve, 3'd1, 16'h00A1, 64'hA1, 16'd3, 1'b0);
    add_req(mrfa_pkg::ReqReserve, 3'd1, 16'h00B0, 64'hB, 16'd2, 1'b0);
    add_req(mrfa_pkg::ReqReserve, 3'd1, 16'h00A1, 64'hA1, 16'd3, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd1, 16'h00A1, 64'hA1, 16'd0, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd1, 16'h00C0, 64'hC, 16'd0, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd1, 16'h00A0, 64'hA, 16'd5, 1'b1);
    add_req(~mrfa_pkg::ReqReserve, 3'd1, 16'h00A0, 64'hA, 16'hFFFF, 1'b1);
    add_req(mrfa_pkg::ReqReserve, 3'd3, 16'h0300, 64'h30, 16'd1, 1'b0);
    for (int i = 0; i < 17; i++)
      add_req(mrfa_pkg::ReqReserve, 3'd3, 16'(16'h0301 + i), 64'h31, 16'd1, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd3, 16'h0300, 64'h30, 16'hFFFF, 1'b1);
    wait_quiet();

    phase_no = 1;
    set_capacities(16'd3, 16'd10, 16'd1, 16'd200);
    run_random(110, 56, 0);
    wait_quiet();

    // whole queue drains in one go: sixteen grants from a single release
    phase_no = 2;
    set_capacities(16'd16, 16'd0, 16'd7, 16'd12);
    add_req(mrfa_pkg::ReqReserve, 3'd0, 16'h0500, 64'h50, 16'd16, 1'b0);
    for (int i = 0; i < 16; i++)
      add_req(mrfa_pkg::ReqReserve, 3'd0, 16'(16'h0600 + i), 64'h60, 16'd1, 1'b0);
    add_req(~mrfa_pkg::ReqReserve, 3'd0, 16'h0500, 64'h50, 16'd16, 1'b1);
    run_random(100, 0, 56);
    wait_quiet();

    // pressure: long receiver hold, then a sender pause until all results are in
    phase_no = 3;
    set_capacities(16'hFFFF, 16'd4, 16'd4, 16'd9);
    run_random(110, 29, 29);
    while (pending_reqs.size() > 55) @(posedge clk);
    sender_pause = 1'b1;
    do @(posedge clk); while (in_valid || expected_results.size() > 0);
    sender_pause = 1'b0;
    wait_quiet();

    phase_no = 4;
    set_capacities(16'd2, 16'hFFFF, 16'd30, 16'd0);
    run_random(110, 0, 0);
    wait_quiet();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("multi_resource_fifo_allocator test passed");
    end else begin
      $display("multi_resource_fifo_allocator test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("multi_resource_fifo_allocator test failed");
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/mrfa_pkg.sv
design/mrfa_datapath.sv
design/mrfa_ctrl.sv
design/multi_resource_fifo_allocator.sv
sim/multi_resource_fifo_allocator_tb.sv
